// File: hdl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define GWF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define GWF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/gwf_pkg.sv
// ----------------------------------------------------------------------------
// gwf_pkg
// Shared types and constants of the water flow grid.
// ----------------------------------------------------------------------------
package gwf_pkg;

  localparam int DEF_GRID_ROWS = 64;
  localparam int DEF_GRID_COLS = 64;

  localparam logic [1:0] KIND_EMPTY = 2'd0;
  localparam logic [1:0] KIND_WATER = 2'd1;
  localparam logic [1:0] KIND_SOLID = 2'd2;

  localparam logic [15:0] LEVEL_FULL = 16'd32768;
  localparam logic [15:0] LEVEL_MAX  = 16'd65535;

  localparam logic [2:0] CMD_PLACE = 3'd0;
  localparam logic [2:0] CMD_SOLID = 3'd1;
  localparam logic [2:0] CMD_CLEAR = 3'd2;
  localparam logic [2:0] CMD_STEP  = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;

  localparam int CFG_AW = 1;
  localparam logic [CFG_AW-1:0] CFG_SIDE_SHIFT = 1'd0;
  localparam logic [CFG_AW-1:0] CFG_STAY_THR   = 1'd1;

  localparam logic [3:0]  SIDE_SHIFT_RST = 4'd2;
  localparam logic [15:0] STAY_THR_RST   = 16'd33;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] level;
  } cell_t;

endpackage

// File: hdl/gwf_bank.sv
// ----------------------------------------------------------------------------
// gwf_bank
// One grid bank: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module gwf_bank
  import gwf_pkg::*;
#(
  parameter int DEPTH = DEF_GRID_ROWS * DEF_GRID_COLS,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  cell_t         wdata,
  input  logic [AW-1:0] raddr,
  output cell_t         rdata
);

  cell_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/grid_water_flow_step_unit.sv
// ----------------------------------------------------------------------------
// grid_water_flow_step_unit
// Grid of empty, water and solid cells with a command port and a flow step.
// ----------------------------------------------------------------------------
//  channel | direction | ports
//  in      | input     | in_valid, in_stall, in_cmd, in_col, in_row
//  out     | output    | out_valid, out_stall, out_kind, out_level, out_done_res
//  cfg     | input     | cfg_we, cfg_addr, cfg_wdata
//
// Every command, a step included, returns one result. A step first clears
// every entry of the next bank, then walks each cell; a water cell reads its
// neighbours below, left and right and pours its flows, which are scaled by
// three divisions when their sum exceeds the level. Each grid bank has one
// read and one write port; the banks swap at the end of a step. After reset
// a pass clears the grid, with in_stall high. A stalled result does not block
// acceptance of the next item, only the delivery of that item's result.
module grid_water_flow_step_unit
  import gwf_pkg::*;
#(
  parameter int GRID_ROWS = DEF_GRID_ROWS,
  parameter int GRID_COLS = DEF_GRID_COLS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        in_cmd,
  input  logic [5:0]        in_col,
  input  logic [5:0]        in_row,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_kind,
  output logic [15:0]       out_level,
  output logic              out_done_res,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [15:0]       cfg_wdata
);

  localparam int CELLS = GRID_ROWS * GRID_COLS;
  localparam int IW    = $clog2(CELLS);
  localparam int RW    = $clog2(GRID_ROWS);
  localparam int CW    = $clog2(GRID_COLS);

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_EXEC, S_SOL, S_RDQ, S_DONE,
    S_CLR, S_C_RD, S_C_EV, S_DN_RD, S_DN_EV, S_L_RD, S_L_EV, S_R_RD, S_R_EV,
    S_SUM, S_MUL, S_DIV, S_PR, S_PW, S_ADV
  } state_t;

  state_t        state_r;
  logic [IW-1:0] clr_r;
  logic          sel_r;
  logic [3:0]    side_shift_r;
  logic [15:0]   stay_thr_r;
  logic [2:0]    cmd_r;
  logic [IW-1:0] cmd_addr_r;
  logic          inside_r;
  logic [1:0]    res_kind_r;
  logic [15:0]   res_level_r;
  logic          out_valid_r;
  logic [1:0]    out_kind_r;
  logic [15:0]   out_level_r;
  logic [IW-1:0] idx_r;
  logic [RW-1:0] row_r;
  logic [CW-1:0] col_r;
  logic [15:0]   lvl_r, q_r, down_r, lf_r, rf_r;
  logic [17:0]   total_r;
  logic [17:0]   rem_r;
  logic [15:0]   sh_r, quo_r;
  logic [3:0]    cnt_r;
  logic [1:0]    div_sel_r;
  logic [1:0]    pour_sel_r;

  // Bank access.
  logic          we, w_cur, wbank;
  logic [IW-1:0] waddr, cur_ra, nxt_ra;
  cell_t         wdata, cur_q, nxt_q, b0_q, b1_q;

  logic [IW-1:0] idx_dn, idx_lt, idx_rt, pour_addr;
  logic [15:0]   pour_amt, stay, flow_mux, side_diff, side_flow, nb_room;
  logic [17:0]   flow_sum, trial;
  logic [16:0]   sat_sum;
  logic [31:0]   prod;
  logic          ge, in_inside;
  logic [IW-1:0] in_addr;

  function automatic logic [15:0] room_of(input logic [15:0] lv);
    return (lv >= LEVEL_FULL) ? 16'd0 : (LEVEL_FULL - lv);
  endfunction

  assign in_inside = (int'(in_col) < GRID_COLS) && (int'(in_row) < GRID_ROWS);
  assign in_addr   = IW'(IW'(in_row) * IW'(GRID_COLS) + IW'(in_col));

  assign idx_dn = idx_r + IW'(GRID_COLS);
  assign idx_lt = idx_r - IW'(1);
  assign idx_rt = idx_r + IW'(1);

  assign flow_sum = {2'b0, down_r} + {2'b0, lf_r} + {2'b0, rf_r};
  // Scaled flows never exceed the level, so the stay fits in 16 bits.
  assign stay     = lvl_r - flow_sum[15:0];

  always_comb begin
    case (pour_sel_r)
      2'd0:    begin pour_addr = idx_dn; pour_amt = down_r; end
      2'd1:    begin pour_addr = idx_lt; pour_amt = lf_r;   end
      2'd2:    begin pour_addr = idx_rt; pour_amt = rf_r;   end
      default: begin pour_addr = idx_r;  pour_amt = stay;   end
    endcase
  end

  assign sat_sum = {1'b0, nxt_q.level} + {1'b0, pour_amt};

  always_comb begin
    case (div_sel_r)
      2'd0:    flow_mux = down_r;
      2'd1:    flow_mux = lf_r;
      default: flow_mux = rf_r;
    endcase
  end

  assign prod  = flow_mux * lvl_r;
  assign trial = {rem_r[16:0], sh_r[15]};
  assign ge    = (trial >= total_r);

  assign side_diff = q_r - cur_q.level;
  assign side_flow = side_diff >> side_shift_r;
  assign nb_room   = room_of(nxt_q.level);

  always_comb begin
    cur_ra = idx_r;
    nxt_ra = idx_r;
    we     = 1'b0;
    w_cur  = 1'b0;
    waddr  = idx_r;
    wdata  = '0;
    case (state_r)
      S_INIT: begin
        we    = 1'b1;
        w_cur = 1'b1;
        waddr = clr_r;
      end
      S_EXEC: begin
        cur_ra = cmd_addr_r;
        waddr  = cmd_addr_r;
        w_cur  = 1'b1;
        if (inside_r && cmd_r == CMD_PLACE) begin
          we    = 1'b1;
          wdata = '{kind: KIND_WATER, level: LEVEL_FULL};
        end else if (inside_r && cmd_r == CMD_CLEAR) begin
          we = 1'b1;
        end
      end
      S_SOL: begin
        we    = 1'b1;
        w_cur = 1'b1;
        waddr = cmd_addr_r;
        wdata = '{kind: KIND_SOLID, level: cur_q.level};
      end
      S_CLR: begin
        we    = 1'b1;
        waddr = clr_r;
      end
      S_C_EV: begin
        if (cur_q.kind == KIND_SOLID) begin
          we    = 1'b1;
          wdata = cur_q;
        end
      end
      S_DN_RD: begin
        cur_ra = idx_dn;
        nxt_ra = idx_dn;
      end
      S_L_RD: begin
        cur_ra = idx_lt;
        nxt_ra = idx_lt;
      end
      S_R_RD: begin
        cur_ra = idx_rt;
        nxt_ra = idx_rt;
      end
      S_PR: begin
        nxt_ra = pour_addr;
        // A stay at or below the threshold empties the cell's next entry.
        if (pour_sel_r == 2'd3 && !(stay > stay_thr_r)) begin
          we = 1'b1;
        end
      end
      S_PW: begin
        we    = 1'b1;
        waddr = pour_addr;
        wdata = '{kind: KIND_WATER, level: sat_sum[16] ? LEVEL_MAX : sat_sum[15:0]};
      end
      default: ;
    endcase
  end

  assign wbank = w_cur ? sel_r : ~sel_r;

  gwf_bank #(.DEPTH(CELLS), .AW(IW)) u_bank0 (
    .clk   (clk),
    .we    (we & ~wbank),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (sel_r ? nxt_ra : cur_ra),
    .rdata (b0_q)
  );

  gwf_bank #(.DEPTH(CELLS), .AW(IW)) u_bank1 (
    .clk   (clk),
    .we    (we & wbank),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (sel_r ? cur_ra : nxt_ra),
    .rdata (b1_q)
  );

  assign cur_q = sel_r ? b1_q : b0_q;
  assign nxt_q = sel_r ? b0_q : b1_q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_INIT;
      clr_r        <= '0;
      sel_r        <= 1'b0;
      out_valid_r  <= 1'b0;
      side_shift_r <= SIDE_SHIFT_RST;
      stay_thr_r   <= STAY_THR_RST;
    end else begin
      if (cfg_we) begin
        if (cfg_addr == CFG_SIDE_SHIFT) begin
          side_shift_r <= cfg_wdata[3:0];
        end else if (cfg_addr == CFG_STAY_THR) begin
          stay_thr_r <= cfg_wdata;
        end
      end
      // In S_DONE the output register is handled by the state itself.
      if (out_valid_r && !out_stall && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_INIT: begin
          clr_r <= clr_r + IW'(1);
          if (clr_r == IW'(CELLS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            cmd_r      <= in_cmd;
            cmd_addr_r <= in_addr;
            inside_r   <= in_inside;
            state_r    <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_kind_r  <= KIND_EMPTY;
          res_level_r <= '0;
          case (cmd_r)
            CMD_SOLID: state_r <= inside_r ? S_SOL : S_DONE;
            CMD_READ:  state_r <= S_RDQ;
            CMD_STEP: begin
              clr_r   <= '0;
              state_r <= S_CLR;
            end
            default:   state_r <= S_DONE;
          endcase
        end
        S_SOL: state_r <= S_DONE;
        S_RDQ: begin
          if (inside_r) begin
            res_kind_r  <= cur_q.kind;
            res_level_r <= cur_q.level;
          end
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= res_kind_r;
            out_level_r <= res_level_r;
            state_r     <= S_IDLE;
          end
        end
        S_CLR: begin
          clr_r <= clr_r + IW'(1);
          if (clr_r == IW'(CELLS - 1)) begin
            idx_r   <= IW'((GRID_ROWS - 1) * GRID_COLS);
            row_r   <= RW'(GRID_ROWS - 1);
            col_r   <= '0;
            state_r <= S_C_RD;
          end
        end
        S_C_RD: state_r <= S_C_EV;
        S_C_EV: begin
          lvl_r   <= cur_q.level;
          state_r <= (cur_q.kind == KIND_WATER) ? S_DN_RD : S_ADV;
        end
        S_DN_RD: begin
          down_r <= '0;
          lf_r   <= '0;
          rf_r   <= '0;
          q_r    <= lvl_r;
          state_r <= (row_r != RW'(GRID_ROWS - 1)) ? S_DN_EV : S_L_RD;
        end
        S_DN_EV: begin
          if (cur_q.kind != KIND_SOLID) begin
            if (lvl_r > nb_room) begin
              down_r <= nb_room;
              q_r    <= lvl_r - nb_room;
            end else begin
              down_r <= lvl_r;
              q_r    <= '0;
            end
          end
          state_r <= S_L_RD;
        end
        S_L_RD: state_r <= (col_r != '0) ? S_L_EV : S_R_RD;
        S_L_EV: begin
          if (cur_q.kind != KIND_SOLID && q_r > cur_q.level) begin
            lf_r <= (side_flow > nb_room) ? nb_room : side_flow;
          end
          state_r <= S_R_RD;
        end
        S_R_RD: state_r <= (col_r != CW'(GRID_COLS - 1)) ? S_R_EV : S_SUM;
        S_R_EV: begin
          if (cur_q.kind != KIND_SOLID && q_r > cur_q.level) begin
            rf_r <= (side_flow > nb_room) ? nb_room : side_flow;
          end
          state_r <= S_SUM;
        end
        S_SUM: begin
          total_r    <= flow_sum;
          div_sel_r  <= '0;
          pour_sel_r <= '0;
          state_r    <= (flow_sum > {2'b0, lvl_r}) ? S_MUL : S_PR;
        end
        S_MUL: begin
          // The quotient is below the flow, so the high half is below the sum.
          rem_r   <= {2'b0, prod[31:16]};
          sh_r    <= prod[15:0];
          quo_r   <= '0;
          cnt_r   <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          rem_r <= ge ? (trial - total_r) : trial;
          sh_r  <= {sh_r[14:0], 1'b0};
          quo_r <= {quo_r[14:0], ge};
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == 4'd15) begin
            case (div_sel_r)
              2'd0:    down_r <= {quo_r[14:0], ge};
              2'd1:    lf_r   <= {quo_r[14:0], ge};
              default: rf_r   <= {quo_r[14:0], ge};
            endcase
            div_sel_r <= div_sel_r + 2'd1;
            state_r   <= (div_sel_r == 2'd2) ? S_PR : S_MUL;
          end
        end
        S_PR: begin
          if (pour_sel_r == 2'd3) begin
            state_r <= (stay > stay_thr_r) ? S_PW : S_ADV;
          end else if (pour_amt != '0) begin
            state_r <= S_PW;
          end else begin
            pour_sel_r <= pour_sel_r + 2'd1;
          end
        end
        S_PW: begin
          pour_sel_r <= pour_sel_r + 2'd1;
          state_r    <= (pour_sel_r == 2'd3) ? S_ADV : S_PR;
        end
        S_ADV: begin
          if (col_r == CW'(GRID_COLS - 1)) begin
            if (row_r == '0) begin
              sel_r   <= ~sel_r;
              state_r <= S_DONE;
            end else begin
              row_r   <= row_r - RW'(1);
              col_r   <= '0;
              idx_r   <= idx_r - IW'(2 * GRID_COLS - 1);
              state_r <= S_C_RD;
            end
          end else begin
            col_r   <= col_r + CW'(1);
            idx_r   <= idx_r + IW'(1);
            state_r <= S_C_RD;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall     = (state_r != S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_kind     = out_kind_r;
  assign out_level    = out_level_r;
  assign out_done_res = 1'b1;

endmodule

// File: hdl/gwf_checker.sv
// ----------------------------------------------------------------------------
// gwf_checker
// Port-level checks of the water flow grid, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gwf_checker
  import gwf_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic [2:0]        in_cmd,
  input logic [5:0]        in_col,
  input logic [5:0]        in_row,
  input logic              out_valid,
  input logic              out_stall,
  input logic [1:0]        out_kind,
  input logic [15:0]       out_level,
  input logic              out_done_res,
  input logic              cfg_we,
  input logic [CFG_AW-1:0] cfg_addr,
  input logic [15:0]       cfg_wdata
);

  // A stalled result stays offered.
  `GWF_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid, "result dropped")
  // Every result reports completion and a legal kind.
  `GWF_ASSERT(a_done, clk, rst_n, out_valid |-> out_done_res && out_kind != 2'd3, "bad result")
  // Reset empties the output and the grid clear keeps the input stalled.
  `GWF_ASSERT_ALWAYS(a_rst, clk, !rst_n |=> !out_valid && in_stall, "reset state wrong")
  // After an item is accepted, the input is stalled in the following cycle.
  `GWF_ASSERT(a_lat, clk, rst_n, in_valid && !in_stall |=> in_stall, "item not taken")

endmodule

bind grid_water_flow_step_unit gwf_checker u_gwf_checker (.*);

// File: dv/grid_water_flow_step_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_water_flow_step_unit_tb
// Drives grid commands and flow steps into the water grid unit and compares
// every result with a cycle-free model of the grid, under random idling on
// both sides, a long result hold-off and several register settings.
// ----------------------------------------------------------------------------
module grid_water_flow_step_unit_tb;
  import gwf_pkg::*;

  localparam int ROWS  = 64;
  localparam int COLS  = 64;
  localparam int CELLS = ROWS * COLS;

  typedef struct {
    logic [2:0] cmd;
    logic [5:0] col;
    logic [5:0] row;
    int         gap;
  } grid_cmd_t;

  typedef struct {
    logic [1:0]  kind;
    logic [15:0] level;
    logic        done_res;
  } cell_answer_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [2:0]        in_cmd = '0;
  logic [5:0]        in_col = '0;
  logic [5:0]        in_row = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [1:0]        out_kind;
  logic [15:0]       out_level;
  logic              out_done_res;
  logic              cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [15:0]       cfg_wdata = '0;

  // Model state: current grid, grid under construction and register copies.
  logic [1:0]  grid_kind [CELLS];
  logic [15:0] grid_level[CELLS];
  logic [1:0]  nxt_kind  [CELLS];
  logic [15:0] nxt_level [CELLS];
  logic [3:0]  flow_shift = SIDE_SHIFT_RST;
  logic [15:0] dry_limit  = STAY_THR_RST;

  grid_cmd_t    cmd_fifo[$];
  cell_answer_t expected_answers[$];
  int           issued_cnt = 0;
  int           accepted_cnt = 0;
  int           err_cnt = 0;
  int           hold_len = 0;
  bit           no_idle = 1'b0;

  grid_water_flow_step_unit dut (.*);

  always #6 clk = ~clk;

  function automatic int unsigned room_left(int i);
    return (nxt_level[i] >= LEVEL_FULL) ? 0 : LEVEL_FULL - nxt_level[i];
  endfunction

  function automatic void add_water(int i, int unsigned amt);
    int unsigned s;
    s = nxt_level[i] + amt;
    nxt_level[i] = (s > LEVEL_MAX) ? LEVEL_MAX : s[15:0];
    nxt_kind[i]  = KIND_WATER;
  endfunction

  function automatic void flow_cell(int r, int c);
    int          i;
    int unsigned lvl, q, dn, lf, rf, tot, stay, cap, nb;
    i = r * COLS + c;
    lvl = 32'(grid_level[i]);
    q = lvl;
    dn = 0;
    lf = 0;
    rf = 0;
    if (r + 1 < ROWS && grid_kind[i + COLS] != KIND_SOLID) begin
      cap = room_left(i + COLS);
      dn = (q > cap) ? cap : q;
      q -= dn;
    end
    if (c > 0 && grid_kind[i - 1] != KIND_SOLID) begin
      nb = 32'(grid_level[i - 1]);
      if (q > nb) begin
        cap = room_left(i - 1);
        lf = (q - nb) >> flow_shift;
        if (lf > cap) lf = cap;
      end
    end
    if (c + 1 < COLS && grid_kind[i + 1] != KIND_SOLID) begin
      nb = 32'(grid_level[i + 1]);
      if (q > nb) begin
        cap = room_left(i + 1);
        rf = (q - nb) >> flow_shift;
        if (rf > cap) rf = cap;
      end
    end
    tot = dn + lf + rf;
    if (tot > lvl) begin
      dn = 32'((64'(dn) * lvl) / tot);
      lf = 32'((64'(lf) * lvl) / tot);
      rf = 32'((64'(rf) * lvl) / tot);
    end
    if (dn > 0) add_water(i + COLS, dn);
    if (lf > 0) add_water(i - 1, lf);
    if (rf > 0) add_water(i + 1, rf);
    stay = lvl - (dn + lf + rf);
    // A small remainder empties the cell and drops what already flowed in.
    if (stay > dry_limit) begin
      add_water(i, stay);
    end else begin
      nxt_kind[i]  = KIND_EMPTY;
      nxt_level[i] = '0;
    end
  endfunction

  function automatic void advance_grid();
    int i;
    for (i = 0; i < CELLS; i++) begin
      nxt_kind[i]  = KIND_EMPTY;
      nxt_level[i] = '0;
    end
    for (int r = ROWS - 1; r >= 0; r--) begin
      for (int c = 0; c < COLS; c++) begin
        i = r * COLS + c;
        if (grid_kind[i] == KIND_SOLID) begin
          nxt_kind[i]  = grid_kind[i];
          nxt_level[i] = grid_level[i];
        end else if (grid_kind[i] == KIND_WATER) begin
          flow_cell(r, c);
        end
      end
    end
    grid_kind  = nxt_kind;
    grid_level = nxt_level;
  endfunction

  function automatic cell_answer_t apply_command(grid_cmd_t it);
    cell_answer_t a;
    int           i;
    i = it.row * COLS + it.col;
    a.kind = '0;
    a.level = '0;
    a.done_res = 1'b1;
    case (it.cmd)
      CMD_PLACE: begin
        grid_kind[i]  = KIND_WATER;
        grid_level[i] = LEVEL_FULL;
      end
      CMD_SOLID: grid_kind[i] = KIND_SOLID;
      CMD_CLEAR: begin
        grid_kind[i]  = KIND_EMPTY;
        grid_level[i] = '0;
      end
      CMD_STEP: advance_grid();
      CMD_READ: begin
        a.kind  = grid_kind[i];
        a.level = grid_level[i];
      end
      default: ;
    endcase
    return a;
  endfunction

  // Input driver: one item at a time, the expectation is formed on acceptance.
  initial begin
    grid_cmd_t it;
    for (int i = 0; i < CELLS; i++) begin
      grid_kind[i]  = KIND_EMPTY;
      grid_level[i] = '0;
    end
    forever begin
      if (cmd_fifo.size() == 0) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end else begin
        it = cmd_fifo.pop_front();
        if (it.gap > 0) begin
          in_valid <= 1'b0;
          repeat (it.gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_cmd   <= it.cmd;
        in_col   <= it.col;
        in_row   <= it.row;
        do @(posedge clk); while (in_stall);
        expected_answers.push_back(apply_command(it));
        accepted_cnt++;
      end
    end
  end

  // Result receiver and checker.
  initial begin
    cell_answer_t exp_a;
    int           k;
    @(posedge rst_n);
    forever begin
      k = no_idle ? 0 : $urandom_range(0, 13);
      if (hold_len > 0) begin
        k = hold_len;
        hold_len = 0;
      end
      if (k > 0) begin
        out_stall <= 1'b1;
        repeat (k) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid && hold_len == 0);
      if (out_valid) begin
        if (expected_answers.size() == 0) begin
          $error("result with no command pending");
          err_cnt++;
        end else begin
          exp_a = expected_answers.pop_front();
          if (out_kind !== exp_a.kind) begin
            $error("kind: expected %0d, got %0d", exp_a.kind, out_kind);
            err_cnt++;
          end
          if (out_level !== exp_a.level) begin
            $error("level: expected %0d, got %0d", exp_a.level, out_level);
            err_cnt++;
          end
          if (out_done_res !== exp_a.done_res) begin
            $error("done_res: expected %0d, got %0d", exp_a.done_res, out_done_res);
            err_cnt++;
          end
        end
      end
    end
  end

  task automatic send_cmd(logic [2:0] cmd, int col = 0, int row = 0, int gap = -1);
    grid_cmd_t it;
    it.cmd = cmd;
    it.col = col[5:0];
    it.row = row[5:0];
    it.gap = (gap >= 0) ? gap : (no_idle ? 0 : $urandom_range(0, 13));
    cmd_fifo.push_back(it);
    issued_cnt++;
    while (cmd_fifo.size() > 1) @(posedge clk);
  endtask

  task automatic wait_drained();
    while (accepted_cnt != issued_cnt || expected_answers.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] addr, logic [15:0] data);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (addr == CFG_SIDE_SHIFT) flow_shift = data[3:0];
    else dry_limit = data;
  endtask

  // Mostly commands near the bottom corners, where water piles up and flows.
  task automatic send_random_cmd();
    int          p, col, row;
    logic [2:0] cmd;
    p = $urandom_range(0, 99);
    if (p < 8) cmd = CMD_STEP;
    else if (p < 12) cmd = 3'($urandom_range(5, 7));
    else if (p < 40) cmd = CMD_PLACE;
    else if (p < 50) cmd = CMD_SOLID;
    else if (p < 57) cmd = CMD_CLEAR;
    else cmd = CMD_READ;
    if ($urandom_range(0, 4) == 0) begin
      col = $urandom_range(0, 63);
      row = $urandom_range(0, 63);
    end else begin
      col = $urandom_range(0, 1) ? $urandom_range(0, 5) : $urandom_range(58, 63);
      row = $urandom_range(57, 63);
    end
    send_cmd(cmd, col, row);
  endtask

  task automatic test_directed();
    send_cmd(CMD_READ, 0, 0);
    send_cmd(CMD_READ, 63, 63);
    send_cmd(CMD_PLACE, 0, 63);
    send_cmd(CMD_PLACE, 63, 63);
    send_cmd(CMD_PLACE, 0, 0);
    send_cmd(CMD_PLACE, 63, 0);
    send_cmd(CMD_PLACE, 10, 62);
    send_cmd(CMD_SOLID, 10, 63);
    send_cmd(CMD_PLACE, 20, 60);
    send_cmd(CMD_SOLID, 20, 60);
    send_cmd(CMD_READ, 20, 60);
    send_cmd(CMD_CLEAR, 0, 0);
    send_cmd(3'd5, 42, 21);
    send_cmd(3'd6, 21, 42);
    send_cmd(3'd7, 63, 63);
    send_cmd(CMD_STEP);
    send_cmd(CMD_READ, 0, 63);
    send_cmd(CMD_READ, 1, 63);
    send_cmd(CMD_READ, 10, 62);
    send_cmd(CMD_READ, 9, 62);
    send_cmd(CMD_READ, 63, 1);
    send_cmd(CMD_STEP);
    send_cmd(CMD_READ, 63, 2);
    send_cmd(CMD_READ, 20, 60);
  endtask

  task automatic test_random_phase(int n);
    for (int i = 0; i < n; i++) send_random_cmd();
  endtask

  task automatic test_back_pressure();
    wait_drained();
    hold_len = 400;
    no_idle = 1'b1;
    for (int i = 0; i < 20; i++) send_cmd(CMD_READ, $urandom_range(0, 7), 63 - (i % 6));
    no_idle = 1'b0;
  endtask

  task automatic test_settings();
    write_reg(CFG_SIDE_SHIFT, 16'd0);
    write_reg(CFG_STAY_THR, 16'd0);
    test_random_phase(10);
    write_reg(CFG_SIDE_SHIFT, 16'hFFFF);
    write_reg(CFG_STAY_THR, 16'd32768);
    test_random_phase(10);
    write_reg(CFG_SIDE_SHIFT, 16'd1);
    write_reg(CFG_STAY_THR, 16'd500);
    no_idle = 1'b1;
    test_random_phase(10);
    no_idle = 1'b0;
    write_reg(CFG_STAY_THR, 16'hFFFF);
    test_random_phase(10);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_phase(16);
    test_back_pressure();
    test_settings();
    wait_drained();
    repeat (50) @(posedge clk);
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
